// ===== rtl/core/fpp_pkg.sv =====
package fpp_pkg;

	// Parser phases within one PDU.
	typedef enum logic [2:0] {
		PH_HDR,
		PH_LEN1,
		PH_LEN2,
		PH_NUM,
		PH_EVH,
		PH_PAY,
		PH_DONE,
		PH_SINK
	} phase_t;

	// Record kinds.
	localparam logic [2:0] KIND_KEY       = 3'd0;
	localparam logic [2:0] KIND_MOUSE     = 3'd1;
	localparam logic [2:0] KIND_MOUSE_EXT = 3'd2;
	localparam logic [2:0] KIND_SYNC      = 3'd3;
	localparam logic [2:0] KIND_UNICODE   = 3'd4;
	localparam logic [2:0] KIND_REL_MOUSE = 3'd5;
	localparam logic [2:0] KIND_TIMESTAMP = 3'd6;
	localparam logic [2:0] KIND_END       = 3'd7;

	// Event code that has no meaning.
	localparam logic [2:0] CODE_UNKNOWN = 3'd7;

	// Closing status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_ACTION = 3'd1;
	localparam logic [2:0] ST_ENCRYPTED  = 3'd2;
	localparam logic [2:0] ST_LEN_MISM   = 3'd3;
	localparam logic [2:0] ST_UNKNOWN    = 3'd4;
	localparam logic [2:0] ST_TRUNCATED  = 3'd5;
	localparam logic [2:0] ST_TRAILING   = 3'd6;

	// Header flag bits, found in bits 7..6 of the header byte.
	localparam logic [1:0] HDR_FLAG_CHECKSUM = 2'h1;
	localparam logic [1:0] HDR_FLAG_ENCRYPT  = 2'h2;

	localparam int LEN_W       = 15;
	localparam int PAYLOAD_W   = 48;
	localparam int OUT_TDATA_W = 72;
	localparam int IN_TDATA_W  = 8;

	// One result record.
	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  key_flags;
		logic [15:0] pointer_flags;
		logic [31:0] value_a;
		logic [15:0] value_b;
		logic [2:0]  status;
		logic        last;
	} rec_t;

	// Payload length in bytes for each event code.
	function automatic logic [2:0] payload_len(input logic [2:0] code);
		logic [2:0] len;
		case (code)
			3'd0: len = 3'd1;
			3'd1: len = 3'd6;
			3'd2: len = 3'd6;
			3'd3: len = 3'd0;
			3'd4: len = 3'd2;
			3'd5: len = 3'd6;
			3'd6: len = 3'd4;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/core/fast_path_input_pdu_parser_top.sv =====
// Fast-path input PDU parser. PDU bytes enter on the s_ stream, one byte per word, with
// s_tlast on the final byte of each PDU. The parser checks the header, reads the one- or
// two-byte length and the event count, and sends one record on the m_ stream for every
// completed event, followed by a closing status record (kind 7, m_tlast high) after the
// final byte. Events of a PDU that closes with a nonzero status are sent before the status
// is known, so the consumer must drop them. Each byte is parsed in the cycle it is accepted,
// and its records are offered on the m_ stream from the next cycle on. A byte is taken every
// cycle as long as the four-entry result queue has room for two records; a final byte that
// also completes an event yields two records, and the queue absorbs the second one, so with
// a ready consumer the input keeps taking one byte per cycle.
module fast_path_input_pdu_parser_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fpp_pkg::IN_TDATA_W-1:0]      s_tdata,  // [7:0] in_byte
	input  logic                                s_tlast,  // pdu_end
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] key_flags, [18:3] pointer_flags, [50:19] value_a, [66:51] value_b,
	// [69:67] status, [71:70] zero
	output logic [fpp_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [2:0]                          m_tuser,  // [2:0] out_kind
	output logic                                m_tlast   // last
);
	import fpp_pkg::*;

	// Parser state.
	phase_t               phase_q;
	logic [LEN_W-1:0]     decl_len_q;
	logic [LEN_W-1:0]     byte_cnt_q;
	logic                 cnt_over_q;
	logic [7:0]           events_left_q;
	logic [2:0]           cur_code_q;
	logic [4:0]           cur_flags_q;
	logic [2:0]           pay_idx_q;
	logic [PAYLOAD_W-1:0] pay_q;
	logic [2:0]           err_q;

	// Next-state values.
	phase_t               n_phase;
	logic [LEN_W-1:0]     n_decl_len;
	logic [LEN_W-1:0]     n_byte_cnt;
	logic                 n_cnt_over;
	logic [7:0]           n_events_left;
	logic [2:0]           n_cur_code;
	logic [4:0]           n_cur_flags;
	logic [2:0]           n_pay_idx;
	logic [PAYLOAD_W-1:0] n_pay;
	logic [2:0]           n_err;

	logic [7:0] in_byte;
	logic       pdu_end;
	logic       acc;
	logic       ev_emit;
	rec_t       ev_rec;
	rec_t       st_rec;
	logic [2:0] fin_status;

	// Result queue.
	rec_t       fifo_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] fill_q;
	logic       push0;
	logic       push1;
	rec_t       rec0;
	logic       pop;
	rec_t       head;

	assign in_byte = s_tdata[7:0];
	assign pdu_end = s_tlast;
	assign acc     = s_tvalid && s_tready;

	// Build an event record from the code, flags and collected payload.
	function automatic rec_t make_event(input logic [2:0] code, input logic [4:0] flags,
			input logic [PAYLOAD_W-1:0] s);
		rec_t r;
		r = '0;
		case (code)
			KIND_KEY: begin
				r.kind      = KIND_KEY;
				r.key_flags = flags[2:0];
				r.value_a   = {24'd0, s[7:0]};
			end
			KIND_MOUSE, KIND_MOUSE_EXT, KIND_REL_MOUSE: begin
				r.kind          = code;
				r.pointer_flags = s[15:0];
				r.value_a       = {16'd0, s[31:16]};
				r.value_b       = s[47:32];
			end
			KIND_SYNC: begin
				r.kind    = KIND_SYNC;
				r.value_a = {27'd0, flags};
			end
			KIND_UNICODE: begin
				r.kind      = KIND_UNICODE;
				r.key_flags = {2'b00, flags[0]};
				r.value_a   = {16'd0, s[15:0]};
			end
			default: begin
				r.kind    = KIND_TIMESTAMP;
				r.value_a = s[31:0];
			end
		endcase
		return r;
	endfunction

	// Per-byte parse step.
	always_comb begin
		n_phase       = phase_q;
		n_decl_len    = decl_len_q;
		n_byte_cnt    = byte_cnt_q;
		n_cnt_over    = cnt_over_q;
		n_events_left = events_left_q;
		n_cur_code    = cur_code_q;
		n_cur_flags   = cur_flags_q;
		n_pay_idx     = pay_idx_q;
		n_pay         = pay_q;
		n_err         = err_q;
		ev_emit       = 1'b0;

		// Byte count saturates; an overflowing PDU always mismatches its length.
		if (byte_cnt_q == {LEN_W{1'b1}}) begin
			n_cnt_over = 1'b1;
		end else begin
			n_byte_cnt = byte_cnt_q + 1'b1;
		end

		case (phase_q)
			PH_HDR: begin
				if (in_byte[1:0] != 2'b00) begin
					n_err   = ST_BAD_ACTION;
					n_phase = PH_SINK;
				end else if ((in_byte[7:6] & (HDR_FLAG_ENCRYPT | HDR_FLAG_CHECKSUM))
						!= 2'b00) begin
					n_err   = ST_ENCRYPTED;
					n_phase = PH_SINK;
				end else begin
					n_events_left = {4'd0, in_byte[5:2]};
					n_phase       = PH_LEN1;
				end
			end
			PH_LEN1: begin
				if (in_byte[7]) begin
					n_decl_len = {in_byte[6:0], 8'd0};
					n_phase    = PH_LEN2;
				end else begin
					n_decl_len = {7'd0, in_byte};
					n_phase    = (events_left_q == 8'd0) ? PH_NUM : PH_EVH;
				end
			end
			PH_LEN2: begin
				n_decl_len = decl_len_q | {7'd0, in_byte};
				n_phase    = (events_left_q == 8'd0) ? PH_NUM : PH_EVH;
			end
			PH_NUM: begin
				n_events_left = in_byte;
				n_phase       = (in_byte != 8'd0) ? PH_EVH : PH_DONE;
			end
			PH_EVH: begin
				n_cur_code  = in_byte[7:5];
				n_cur_flags = in_byte[4:0];
				n_pay       = '0;
				n_pay_idx   = 3'd0;
				if (in_byte[7:5] == CODE_UNKNOWN) begin
					n_err   = ST_UNKNOWN;
					n_phase = PH_SINK;
				end else if (payload_len(in_byte[7:5]) == 3'd0) begin
					ev_emit       = 1'b1;
					n_events_left = events_left_q - 1'b1;
					n_phase       = (n_events_left != 8'd0) ? PH_EVH : PH_DONE;
				end else begin
					n_phase = PH_PAY;
				end
			end
			PH_PAY: begin
				// Payload bytes land little-endian in the collect register.
				for (int i = 0; i < PAYLOAD_W / 8; i++) begin
					if (pay_idx_q == 3'(i)) begin
						n_pay[8*i +: 8] = in_byte;
					end
				end
				n_pay_idx = pay_idx_q + 1'b1;
				if (n_pay_idx >= payload_len(cur_code_q)) begin
					ev_emit       = 1'b1;
					n_events_left = events_left_q - 1'b1;
					n_phase       = (n_events_left != 8'd0) ? PH_EVH : PH_DONE;
				end
			end
			PH_DONE: begin
				n_err   = ST_TRAILING;
				n_phase = PH_SINK;
			end
			default: begin
			end
		endcase

		// Closing status, in order of precedence.
		if (n_err == ST_BAD_ACTION || n_err == ST_ENCRYPTED) begin
			fin_status = n_err;
		end else if (n_phase == PH_HDR || n_phase == PH_LEN1 || n_phase == PH_LEN2) begin
			fin_status = ST_TRUNCATED;
		end else if (n_cnt_over || n_decl_len != n_byte_cnt) begin
			fin_status = ST_LEN_MISM;
		end else if (n_err == ST_UNKNOWN) begin
			fin_status = ST_UNKNOWN;
		end else if (n_phase == PH_NUM || n_phase == PH_EVH || n_phase == PH_PAY) begin
			fin_status = ST_TRUNCATED;
		end else if (n_err == ST_TRAILING) begin
			fin_status = ST_TRAILING;
		end else begin
			fin_status = ST_OK;
		end

		ev_rec        = make_event(n_cur_code, n_cur_flags, n_pay);
		st_rec        = '0;
		st_rec.kind   = KIND_END;
		st_rec.status = fin_status;
		st_rec.last   = 1'b1;

		// The final byte returns the parser to its idle state.
		if (pdu_end) begin
			n_phase       = PH_HDR;
			n_decl_len    = '0;
			n_byte_cnt    = '0;
			n_cnt_over    = 1'b0;
			n_events_left = '0;
			n_cur_code    = '0;
			n_cur_flags   = '0;
			n_pay_idx     = '0;
			n_pay         = '0;
			n_err         = ST_OK;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HDR;
			decl_len_q    <= '0;
			byte_cnt_q    <= '0;
			cnt_over_q    <= 1'b0;
			events_left_q <= '0;
			cur_code_q    <= '0;
			cur_flags_q   <= '0;
			pay_idx_q     <= '0;
			pay_q         <= '0;
			err_q         <= ST_OK;
		end else if (acc) begin
			phase_q       <= n_phase;
			decl_len_q    <= n_decl_len;
			byte_cnt_q    <= n_byte_cnt;
			cnt_over_q    <= n_cnt_over;
			events_left_q <= n_events_left;
			cur_code_q    <= n_cur_code;
			cur_flags_q   <= n_cur_flags;
			pay_idx_q     <= n_pay_idx;
			pay_q         <= n_pay;
			err_q         <= n_err;
		end
	end

	// Up to two records enter the queue per accepted word, event first.
	assign push0    = acc && (ev_emit || pdu_end);
	assign push1    = acc && ev_emit && pdu_end;
	assign rec0     = ev_emit ? ev_rec : st_rec;
	assign pop      = m_tvalid && m_tready;
	assign s_tready = (fill_q <= 3'd2);

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push0) begin
			fifo_q[wr_ptr_q] <= rec0;
		end
		if (push1) begin
			fifo_q[wr_ptr_q + 2'd1] <= st_rec;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + {1'b0, push0} + {1'b0, push1};
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			fill_q   <= fill_q + {2'b00, push0} + {2'b00, push1} - {2'b00, pop};
		end
	end

	// Output word from the queue head.
	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (fill_q != 3'd0);
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {2'b00, head.status, head.value_b, head.value_a,
		head.pointer_flags, head.key_flags};

endmodule

// ===== rtl/core/fpp_checker.sv =====
module fpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);
	import fpp_pkg::*;

	// A status record is always the closing word, and only it is.
	a_end_kind : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == KIND_END) == m_tlast))
		else $error("closing word and end kind disagree");

	// Event records carry a zero status field.
	a_event_status : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[69:67] == ST_OK))
		else $error("event word carries a status");

	// The input stalls only while results are waiting.
	a_stall_cause : assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with an empty result queue");

	// A final byte always produces an output word in the next cycle.
	a_end_result : assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> m_tvalid)
		else $error("no result after final byte");

	// A waiting output word is not withdrawn.
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("output word withdrawn");

endmodule

bind fast_path_input_pdu_parser_top fpp_checker u_fpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== sim/fast_path_input_pdu_parser_top_test.sv =====
module fast_path_input_pdu_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fpp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned HOLD_START   = 400;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned RANDOM_WORDS = 1100;

	// One input word on its way to the sender, with the idle cycles that precede it.
	typedef struct {
		logic [7:0]  val;
		logic        eop;
		int unsigned gap;
	} pdu_word_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [2:0]             m_tuser;
	logic                   m_tlast;

	pdu_word_t   send_q[$];
	logic [7:0]  pdu_buf[$];
	rec_t        expected_recs[$];
	int unsigned words_total = 0;
	int unsigned words_taken = 0;
	int unsigned idle_done   = 0;
	int unsigned stall_left  = 0;
	int unsigned errors      = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_count  = 0;
	logic        hold_off    = 1'b0;
	logic        sender_lazy = 1'b1;
	logic        recv_lazy   = 1'b0;

	// Parser state as predicted by the testbench.
	phase_t      ph         = PH_HDR;
	logic [14:0] want_len   = '0;
	logic [14:0] seen_cnt   = '0;
	logic        seen_over  = 1'b0;
	logic [7:0]  evts_to_go = '0;
	logic [2:0]  ev_code    = '0;
	logic [4:0]  ev_flags   = '0;
	logic [2:0]  pay_cnt    = '0;
	logic [47:0] pay_bits   = '0;
	logic [2:0]  fault      = ST_OK;

	fast_path_input_pdu_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5ns clk = ~clk;

	// Number of payload bytes that follow an event header of the given code.
	function automatic int unsigned payload_bytes(input logic [2:0] code);
		case (code)
			KIND_KEY: return 1;
			KIND_MOUSE, KIND_MOUSE_EXT, KIND_REL_MOUSE: return 6;
			KIND_UNICODE: return 2;
			KIND_TIMESTAMP: return 4;
			default: return 0;
		endcase
	endfunction

	// Record for the event that has just completed.
	function automatic rec_t event_record();
		rec_t r;
		r = '0;
		r.kind = ev_code;
		case (ev_code)
			KIND_KEY: begin
				r.key_flags = ev_flags[2:0];
				r.value_a   = {24'd0, pay_bits[7:0]};
			end
			KIND_MOUSE, KIND_MOUSE_EXT, KIND_REL_MOUSE: begin
				r.pointer_flags = pay_bits[15:0];
				r.value_a       = {16'd0, pay_bits[31:16]};
				r.value_b       = pay_bits[47:32];
			end
			KIND_SYNC: r.value_a = {27'd0, ev_flags};
			KIND_UNICODE: begin
				r.key_flags = {2'b00, ev_flags[0]};
				r.value_a   = {16'd0, pay_bits[15:0]};
			end
			default: r.value_a = pay_bits[31:0];
		endcase
		return r;
	endfunction

	function automatic void end_event();
		evts_to_go = evts_to_go - 8'd1;
		ph = (evts_to_go != 0) ? PH_EVH : PH_DONE;
	endfunction

	// Status of the closing record, in order of precedence.
	function automatic logic [2:0] close_status();
		if (fault == ST_BAD_ACTION || fault == ST_ENCRYPTED)
			return fault;
		if (ph inside {PH_HDR, PH_LEN1, PH_LEN2})
			return ST_TRUNCATED;
		if (seen_over || want_len != seen_cnt)
			return ST_LEN_MISM;
		if (fault == ST_UNKNOWN)
			return ST_UNKNOWN;
		if (ph inside {PH_NUM, PH_EVH, PH_PAY})
			return ST_TRUNCATED;
		if (fault == ST_TRAILING)
			return ST_TRAILING;
		return ST_OK;
	endfunction

	// Advances the predicted parser by one accepted word and queues the records it yields.
	function automatic void parse_byte(input logic [7:0] b, input logic eop);
		rec_t r;
		if (seen_cnt == 15'h7FFF)
			seen_over = 1'b1;
		else
			seen_cnt = seen_cnt + 15'd1;
		case (ph)
			PH_HDR: begin
				if (b[1:0] != 2'b00) begin
					fault = ST_BAD_ACTION;
					ph = PH_SINK;
				end else if ((b[7:6] & (HDR_FLAG_ENCRYPT | HDR_FLAG_CHECKSUM)) != 2'b00) begin
					fault = ST_ENCRYPTED;
					ph = PH_SINK;
				end else begin
					evts_to_go = {4'd0, b[5:2]};
					ph = PH_LEN1;
				end
			end
			PH_LEN1: begin
				if (b[7]) begin
					want_len = {b[6:0], 8'h00};
					ph = PH_LEN2;
				end else begin
					want_len = {8'h00, b[6:0]};
					ph = (evts_to_go == 0) ? PH_NUM : PH_EVH;
				end
			end
			PH_LEN2: begin
				want_len = want_len | {7'd0, b};
				ph = (evts_to_go == 0) ? PH_NUM : PH_EVH;
			end
			PH_NUM: begin
				evts_to_go = b;
				ph = (b != 0) ? PH_EVH : PH_DONE;
			end
			PH_EVH: begin
				ev_code  = b[7:5];
				ev_flags = b[4:0];
				pay_bits = '0;
				pay_cnt  = '0;
				if (ev_code == CODE_UNKNOWN) begin
					fault = ST_UNKNOWN;
					ph = PH_SINK;
				end else if (payload_bytes(ev_code) == 0) begin
					expected_recs.push_back(event_record());
					end_event();
				end else begin
					ph = PH_PAY;
				end
			end
			PH_PAY: begin
				pay_bits[8*pay_cnt +: 8] = b;
				pay_cnt = pay_cnt + 3'd1;
				if (pay_cnt >= payload_bytes(ev_code)) begin
					expected_recs.push_back(event_record());
					end_event();
				end
			end
			PH_DONE: begin
				fault = ST_TRAILING;
				ph = PH_SINK;
			end
			default: ;
		endcase
		if (eop) begin
			r = '0;
			r.kind   = KIND_END;
			r.status = close_status();
			r.last   = 1'b1;
			expected_recs.push_back(r);
			ph         = PH_HDR;
			want_len   = '0;
			seen_cnt   = '0;
			seen_over  = 1'b0;
			evts_to_go = '0;
			ev_code    = '0;
			ev_flags   = '0;
			pay_cnt    = '0;
			pay_bits   = '0;
			fault      = ST_OK;
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compares the record on the output with the oldest one predicted.
	function automatic void check_record();
		rec_t want;
		if (expected_recs.size() == 0) begin
			$display("%0t: unexpected record, expected none, actual kind %0d tdata %h last %b",
				$time, m_tuser, m_tdata, m_tlast);
			errors++;
		end else begin
			want = expected_recs.pop_front();
			compare_field("kind", 32'(want.kind), 32'(m_tuser));
			compare_field("key_flags", 32'(want.key_flags), 32'(m_tdata[2:0]));
			compare_field("pointer_flags", 32'(want.pointer_flags), 32'(m_tdata[18:3]));
			compare_field("value_a", want.value_a, m_tdata[50:19]);
			compare_field("value_b", 32'(want.value_b), 32'(m_tdata[66:51]));
			compare_field("status", 32'(want.status), 32'(m_tdata[69:67]));
			compare_field("last", 32'(want.last), 32'(m_tlast));
		end
	endfunction

	// Queues the PDU in pdu_buf for the sender, final byte flagged.
	task automatic push_pdu();
		pdu_word_t w;
		foreach (pdu_buf[i]) begin
			w.val = pdu_buf[i];
			w.eop = (i == pdu_buf.size() - 1);
			w.gap = sender_lazy ? $urandom_range(0, 13) : 0;
			send_q.push_back(w);
		end
		words_total += pdu_buf.size();
	endtask

	// Builds a random PDU, mostly well formed, sometimes with one flaw, sometimes noise.
	task automatic random_pdu();
		logic [7:0]  body[$];
		logic [7:0]  hdr;
		logic [2:0]  code;
		logic [14:0] len;
		logic        count_byte;
		logic        long_len;
		int unsigned nev;
		int unsigned made;
		int unsigned total;
		int unsigned flaw;
		int unsigned cut;
		flaw = $urandom_range(0, 19);
		pdu_buf.delete();
		if (flaw == 5) begin
			repeat ($urandom_range(1, 6))
				pdu_buf.push_back(8'($urandom));
			push_pdu();
			return;
		end
		count_byte = ($urandom_range(0, 3) == 0);
		if (count_byte)
			nev = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
		else
			nev = $urandom_range(1, $urandom_range(1, 15));
		made = (nev > 15) ? 15 : nev;

		// Events, the last one replaced by an unknown code when that flaw is drawn.
		for (int i = 0; i < made; i++) begin
			code = (flaw == 4 && i == made - 1) ? CODE_UNKNOWN : 3'($urandom_range(0, 6));
			body.push_back({code, 5'($urandom)});
			repeat (payload_bytes(code))
				body.push_back(8'($urandom));
		end
		if (flaw == 4 || flaw == 6) begin
			repeat ($urandom_range(1, 3))
				body.push_back(8'($urandom));
		end
		if (flaw == 3 && body.size() > 1) begin
			cut = $urandom_range(0, body.size() - 1);
			while (body.size() > cut)
				void'(body.pop_back());
		end

		// Header and length, then the body.
		hdr = {2'b00, count_byte ? 4'd0 : 4'(nev), 2'b00};
		if (flaw == 0)
			hdr[1:0] = 2'($urandom_range(1, 3));
		if (flaw == 1)
			hdr[7:6] = 2'($urandom_range(1, 3));
		total = 2 + (count_byte ? 1 : 0) + body.size();
		long_len = (total > 127) || ($urandom_range(0, 3) == 0);
		if (long_len)
			total++;
		len = 15'(total);
		if (flaw == 2)
			len = long_len ? 15'($urandom) : 15'($urandom_range(0, 127));
		pdu_buf.push_back(hdr);
		if (long_len) begin
			pdu_buf.push_back({1'b1, len[14:8]});
			pdu_buf.push_back(len[7:0]);
		end else begin
			pdu_buf.push_back({1'b0, len[6:0]});
		end
		if (count_byte)
			pdu_buf.push_back(8'(nev));
		foreach (body[i])
			pdu_buf.push_back(body[i]);
		if (flaw == 7) begin
			cut = $urandom_range(1, pdu_buf.size() - 1);
			while (pdu_buf.size() > cut)
				void'(pdu_buf.pop_back());
		end
		push_pdu();
	endtask

	// Stimulus, reset and end of run.
	initial begin
		pdu_buf = '{8'h00};
		push_pdu();
		pdu_buf = '{8'h01};
		push_pdu();
		pdu_buf = '{8'h80};
		push_pdu();
		pdu_buf = '{8'h40, 8'h05};
		push_pdu();
		pdu_buf = '{8'h42, 8'h05};
		push_pdu();
		pdu_buf = '{8'h04, 8'h03, 8'h7F};
		push_pdu();
		pdu_buf = '{8'h00, 8'h03, 8'h00};
		push_pdu();
		pdu_buf = '{8'h04, 8'h03, 8'hE0};
		push_pdu();
		pdu_buf = '{8'h04, 8'h04, 8'h07, 8'hFF};
		push_pdu();
		pdu_buf = '{8'h00, 8'h80};
		push_pdu();
		pdu_buf = '{8'h04, 8'h05, 8'h7F};
		push_pdu();
		pdu_buf = '{8'h04, 8'h04, 8'h7F, 8'hAA};
		push_pdu();

		while (words_total < RANDOM_WORDS) begin
			if ($urandom_range(0, 3) == 0)
				sender_lazy = !sender_lazy;
			random_pdu();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken != words_total) @(negedge clk);
		while (expected_recs.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && expected_recs.size() == 0) begin
			$display("fast_path_input_pdu_parser_top_test OK");
		end else begin
			$display("fast_path_input_pdu_parser_top_test NOT OK");
		end
		$finish;
	end

	// Sender: offers queued words, idling before each as drawn, and predicts accepted ones.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			idle_done = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tlast);
				words_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (idle_done < send_q[0].gap) begin
					idle_done++;
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= send_q[0].val;
					s_tlast  <= send_q[0].eop;
					send_q.delete(0);
					idle_done = 0;
				end
			end
		end
	end

	// Receiver: checks each accepted record and stalls for a drawn number of cycles after it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			recv_lazy = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_record();
				if ($urandom_range(0, 31) == 0)
					recv_lazy = !recv_lazy;
				stall_left = recv_lazy ? $urandom_range(0, 13) : 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !hold_off;
			end
		end
	end

	// One long receiver hold-off so that the result queue fills and the input stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count <= 0;
			hold_off   <= 1'b0;
		end else begin
			hold_count <= hold_count + 1;
			hold_off   <= (hold_count >= HOLD_START) && (hold_count < HOLD_START + HOLD_CYCLES);
		end
	end

	// Timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("fast_path_input_pdu_parser_top_test NOT OK");
			$finish;
		end
	end

endmodule

// ===== fast_path_input_pdu_parser_top.f =====
rtl/core/fpp_pkg.sv
rtl/core/fast_path_input_pdu_parser_top.sv
rtl/core/fpp_checker.sv
sim/fast_path_input_pdu_parser_top_test.sv
